// ===== rtl/skct_pkg.sv =====
// skct_pkg: field widths, operation and status codes, and the entry type
// shared by the sorted key count table. No dependencies.
package skct_pkg;

    localparam int KIND_W    = 2;
    localparam int SET_W     = 8;
    localparam int KEY_W     = 64;
    localparam int CNT_W     = 32;
    localparam int POS_W     = 10;
    localparam int STATUS_W  = 3;
    localparam int OCC_OUT_W = 11;

    // Operation codes; bit KIND_CLEAR_BIT set means clear, whatever bit 0 says
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam int                KIND_CLEAR_BIT = 1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NEW    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INCR   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEAR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADSET = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd6;

    // One stored entry: key and its wrapping count
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

// ===== rtl/skct_req_if.sv =====
// skct_req_if: request channel (valid/ready plus operation fields).
// Depends on skct_pkg.
interface skct_req_if
    import skct_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [SET_W-1:0]         set_index;
    logic [KEY_W-1:0]         key;
    logic signed [CNT_W-1:0]  increment;
    logic [POS_W-1:0]         position;

    modport source (output valid, kind, set_index, key, increment, position,
                    input ready);
    modport sink   (input valid, kind, set_index, key, increment, position,
                    output ready);
endinterface

// ===== rtl/skct_rsp_if.sv =====
// skct_rsp_if: result channel (valid/ready plus result fields).
// Depends on skct_pkg.
interface skct_rsp_if
    import skct_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [KEY_W-1:0]         entry_key;
    logic signed [CNT_W-1:0]  entry_count;
    logic [OCC_OUT_W-1:0]     set_occupancy;

    modport source (output valid, status, entry_key, entry_count, set_occupancy,
                    input ready);
    modport sink   (input valid, status, entry_key, entry_count, set_occupancy,
                    output ready);
endinterface

// ===== rtl/skct_occ_table.sv =====
// skct_occ_table: per-set occupancy memory with one valid flop per set, so a
// clear empties every set at once. No dependencies.
module skct_occ_table #(
    parameter int NUM_SETS = 32,
    parameter int SW       = 5,
    parameter int CW       = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [CW-1:0] rd_occ,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [CW-1:0] wr_occ,
    input  logic          clear
);
    logic [CW-1:0]       mem [NUM_SETS];
    logic [NUM_SETS-1:0] valid_reg;
    logic [CW-1:0]       rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_occ;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written or cleared sets read as empty
    assign rd_occ = rd_valid_reg ? rd_data_reg : '0;
endmodule

// ===== rtl/skct_entry_mem.sv =====
// skct_entry_mem: key/count entry store, one write and one registered read
// per cycle. Depends on skct_pkg (entry_t).
module skct_entry_mem
    import skct_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/sorted_key_count_table.sv =====
// Sequence: clear and bad set go straight to the result; a read fetches the occupancy,
// then the entry; an insert fetches the occupancy, makes p probes (p <= ceil(log2(n+1)),
// n = occupancy), then updates a found key, or moves n - i entries up (i = sorted slot)
// and places the key. Throughput: one item at a time; shift moves one entry per cycle.
// Reset: asynchronous, active low; all sets empty at once (valid flops), no sweep.
// Depends on skct_pkg, skct_req_if, skct_rsp_if, skct_occ_table, skct_entry_mem.
module sorted_key_count_table
    import skct_pkg::*;
#(
    parameter int NUM_SETS     = 32,
    parameter int SET_CAPACITY = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    skct_req_if.sink   req,
    skct_rsp_if.source rsp
);
    // CW holds an occupancy (0..SET_CAPACITY); SW addresses a set
    localparam int CW    = $clog2(SET_CAPACITY + 1);
    localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int DEPTH = NUM_SETS * SET_CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (CW > POS_W) ? CW : POS_W;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_OCC       = 3'd1;  // occupancy read returns
    localparam logic [2:0] S_SEARCH    = 3'd2;  // binary search: issue probe
    localparam logic [2:0] S_SRCH_WAIT = 3'd3;  // binary search: compare probe
    localparam logic [2:0] S_MATCH     = 3'd4;  // compare key at lower bound
    localparam logic [2:0] S_READ      = 3'd5;  // read data returns
    localparam logic [2:0] S_SHIFT     = 3'd6;  // move entries up, then place
    localparam logic [2:0] S_DONE      = 3'd7;  // hand result to output register

    logic [2:0]           state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [SET_W-1:0]     set_reg, set_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]     incr_reg, incr_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;   // probe index / shift read cursor
    logic [CW-1:0]        wr_idx_reg, wr_idx_next;
    logic                 wr_pend_reg, wr_pend_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [KEY_W-1:0]     res_key_reg, res_key_next;
    logic [CNT_W-1:0]     res_count_reg, res_count_next;
    logic [OCC_OUT_W-1:0] res_occ_reg, res_occ_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [KEY_W-1:0]     out_key_reg, out_key_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;
    logic [OCC_OUT_W-1:0] out_occ_reg, out_occ_next;

    // memory controls
    logic                 occ_rd_en, occ_we, occ_clear;
    logic [CW-1:0]        occ_rd, occ_wr;
    logic                 ent_rd_en, ent_we;
    logic [CW-1:0]        ent_rd_idx, ent_wr_idx;
    entry_t               ent_rd, ent_wr;
    logic [CW:0]          mid_sum;
    logic                 req_xfer;

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        set_next        = set_reg;
        key_next        = key_reg;
        incr_next       = incr_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        wr_pend_next    = wr_pend_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_count_next  = res_count_reg;
        res_occ_next    = res_occ_reg;

        // output register drains independently of the sequencer
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_count_next  = out_count_reg;
        out_occ_next    = out_occ_reg;

        occ_rd_en  = 1'b0;
        occ_we     = 1'b0;
        occ_clear  = 1'b0;
        occ_wr     = CW'(n_reg + CW'(1));
        ent_rd_en  = 1'b0;
        ent_rd_idx = rd_idx_reg;
        ent_we     = 1'b0;
        ent_wr_idx = wr_idx_reg;
        ent_wr     = ent_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    kind_next      = req.kind;
                    set_next       = req.set_index;
                    key_next       = req.key;
                    incr_next      = req.increment;
                    pos_next       = req.position;
                    base_next      = AW'(req.set_index[SW-1:0]) * AW'(SET_CAPACITY);
                    occ_rd_en      = 1'b1;
                    res_key_next   = '0;
                    res_count_next = '0;
                    res_occ_next   = '0;
                    if (req.kind[KIND_CLEAR_BIT])
                    begin
                        occ_clear       = 1'b1;
                        res_status_next = ST_CLEAR;
                        state_next      = S_DONE;
                    end
                    else if ({1'b0, req.set_index} >= (SET_W + 1)'(NUM_SETS))
                    begin
                        res_status_next = ST_BADSET;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OCC;
                    end
                end
            end

            S_OCC:
            begin
                n_next       = occ_rd;
                res_occ_next = OCC_OUT_W'(occ_rd);
                if (kind_reg == KIND_READ)
                begin
                    if (PW'(pos_reg) >= PW'(occ_rd))
                    begin
                        res_status_next = ST_BADPOS;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ent_rd_en  = 1'b1;
                        ent_rd_idx = CW'(pos_reg);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = occ_rd;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_idx  = mid_sum[CW:1];
                    rd_idx_next = mid_sum[CW:1];
                    state_next  = S_SRCH_WAIT;
                end
                else if (lo_reg < n_reg)
                begin
                    ent_rd_en  = 1'b1;
                    ent_rd_idx = lo_reg;
                    state_next = S_MATCH;
                end
                else if (n_reg >= CW'(SET_CAPACITY))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_idx_next  = n_reg;
                    wr_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
            end

            S_SRCH_WAIT:
            begin
                if (ent_rd.key < key_reg)
                begin
                    lo_next = CW'(rd_idx_reg + CW'(1));
                end
                else
                begin
                    hi_next = rd_idx_reg;
                end
                state_next = S_SEARCH;
            end

            S_MATCH:
            begin
                if (ent_rd.key == key_reg)
                begin
                    // existing key: count wraps mod 2^32
                    ent_we          = 1'b1;
                    ent_wr_idx      = lo_reg;
                    ent_wr.key      = ent_rd.key;
                    ent_wr.count    = ent_rd.count + incr_reg;
                    res_status_next = ST_INCR;
                    state_next      = S_DONE;
                end
                else if (n_reg >= CW'(SET_CAPACITY))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_idx_next  = n_reg;
                    wr_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
            end

            S_READ:
            begin
                res_status_next = ST_READ;
                res_key_next    = ent_rd.key;
                res_count_next  = ent_rd.count;
                state_next      = S_DONE;
            end

            S_SHIFT:
            begin
                // entry read last cycle lands one slot higher
                if (wr_pend_reg)
                begin
                    ent_we     = 1'b1;
                    ent_wr_idx = wr_idx_reg;
                    ent_wr     = ent_rd;
                end
                if (rd_idx_reg > lo_reg)
                begin
                    ent_rd_en    = 1'b1;
                    ent_rd_idx   = CW'(rd_idx_reg - CW'(1));
                    wr_idx_next  = rd_idx_reg;
                    rd_idx_next  = CW'(rd_idx_reg - CW'(1));
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        // gap is open at the lower bound: place the new key
                        ent_we          = 1'b1;
                        ent_wr_idx      = lo_reg;
                        ent_wr.key      = key_reg;
                        ent_wr.count    = incr_reg;
                        occ_we          = 1'b1;
                        res_status_next = ST_NEW;
                        res_occ_next    = OCC_OUT_W'(CW'(n_reg + CW'(1)));
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_key_next    = res_key_reg;
                    out_count_next  = res_count_reg;
                    out_occ_next    = res_occ_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        set_reg        <= set_next;
        key_reg        <= key_next;
        incr_reg       <= incr_next;
        pos_reg        <= pos_next;
        base_reg       <= base_next;
        n_reg          <= n_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_count_reg  <= res_count_next;
        res_occ_reg    <= res_occ_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_count_reg  <= out_count_next;
        out_occ_reg    <= out_occ_next;
    end

    // occupancy per set; read in the accept cycle, written on a new key
    skct_occ_table #(
        .NUM_SETS (NUM_SETS),
        .SW       (SW),
        .CW       (CW)
    ) u_occ (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (occ_rd_en),
        .rd_addr (req.set_index[SW-1:0]),
        .rd_occ  (occ_rd),
        .wr_en   (occ_we),
        .wr_addr (set_reg[SW-1:0]),
        .wr_occ  (occ_wr),
        .clear   (occ_clear)
    );

    // all sets' entries; a set occupies SET_CAPACITY consecutive words
    skct_entry_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_entries (
        .clk     (clk),
        .rd_en   (ent_rd_en),
        .rd_addr (AW'(base_reg + AW'(ent_rd_idx))),
        .rd_data (ent_rd),
        .wr_en   (ent_we),
        .wr_addr (AW'(base_reg + AW'(ent_wr_idx))),
        .wr_data (ent_wr)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_key     = out_key_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.set_occupancy = out_occ_reg;
endmodule

// ===== rtl/skct_checker.sv =====
// skct_checker: port-level checks on the result channel, bound to the top.
// Depends on skct_pkg and sorted_key_count_table.
module skct_checker
    import skct_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [STATUS_W-1:0]  rsp_status,
    input logic [KEY_W-1:0]     rsp_entry_key,
    input logic [CNT_W-1:0]     rsp_entry_count,
    input logic [OCC_OUT_W-1:0] rsp_set_occupancy
);
    // stalled result holds its status, key and occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_entry_key) && $stable(rsp_set_occupancy))
        else $error("result changed while stalled");

    // entry fields are zero except on a good read
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_READ) |-> (rsp_entry_key == '0)
            && (rsp_entry_count == '0))
        else $error("entry fields nonzero outside a read");

    // clear and bad set report an empty set
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_CLEAR) || (rsp_status == ST_BADSET))
            |-> (rsp_set_occupancy == '0))
        else $error("occupancy nonzero on clear or bad set");

    // no result comes out straight after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result valid right after reset");
endmodule

bind sorted_key_count_table skct_checker u_skct_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_entry_key     (rsp.entry_key),
    .rsp_entry_count   (rsp.entry_count),
    .rsp_set_occupancy (rsp.set_occupancy)
);

// ===== sim/tb.sv =====
// tb: self-checking bench for sorted_key_count_table, top module tb.
// Depends on skct_pkg, skct_req_if, skct_rsp_if and the RTL of the table.
// Directed table first, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skct_pkg::*;

    localparam int NUM_SETS     = 32;
    localparam int SET_CAPACITY = 1024;

    localparam int RAND_ITEMS = 545;
    localparam int GAP_MAX    = 14;
    localparam int DRAIN      = 40;
    localparam int REPORT_MAX = 50;

    // Slowest legal item: a full binary search and a shift of a whole set, plus GAP_MAX on
    // each side. The limit covers ~570 such items with a 4x margin.
    localparam int LIMIT = 2_500_000;

    // Clear is any kind with the high bit set
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'b10;
    localparam logic [KIND_W-1:0] KIND_CLEAR_HI = 2'b11;

    localparam logic [KEY_W-1:0]        KEY_ONES = '1;
    localparam logic signed [CNT_W-1:0] CNT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN  = 32'sh8000_0000;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [SET_W-1:0]        set_index;
        logic [KEY_W-1:0]        key;
        logic signed [CNT_W-1:0] increment;
        logic [POS_W-1:0]        position;
    } op_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [KEY_W-1:0]        entry_key;
        logic signed [CNT_W-1:0] entry_count;
        logic [OCC_OUT_W-1:0]    set_occupancy;
    } outcome_t;

    typedef struct {
        op_t      op;
        bit       typed;    // want holds a hand-written answer
        outcome_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    skct_req_if req_ch ();
    skct_rsp_if rsp_ch ();

    sorted_key_count_table #(
        .NUM_SETS     (NUM_SETS),
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the table contents, kept in step with accepted requests
    logic [KEY_W-1:0]        key_mirror   [NUM_SETS][SET_CAPACITY];
    logic signed [CNT_W-1:0] count_mirror [NUM_SETS][SET_CAPACITY];
    int                      occ_mirror   [NUM_SETS];

    outcome_t  due_outcomes [$];
    plan_row_t plan [$];

    int  errors;
    int  reported;
    int  sent;
    int  cycles;
    int  status_seen [8];
    bit  quiet;         // when set, neither side inserts idle cycles
    bit  stim_done;

    always #6 clk = ~clk;

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("%0t timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, due_outcomes.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Per-item idle draw; quiet stretches give back-to-back traffic
    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Predictor: applies one request to the mirror and returns the answer.
    // Binary search finds the first slot whose key is not below the new key.
    function automatic outcome_t count_table_step(input op_t o);
        outcome_t res;
        int       s;
        int       n;
        int       lo;
        int       hi;
        int       mid;
        int       j;

        res.status        = ST_NEW;
        res.entry_key     = '0;
        res.entry_count   = '0;
        res.set_occupancy = '0;

        if (o.kind[KIND_CLEAR_BIT])
        begin
            // only occupancy is wiped; stale contents stay unreachable
            for (j = 0; j < NUM_SETS; j++)
                occ_mirror[j] = 0;
            res.status = ST_CLEAR;
            return res;
        end
        if (o.set_index >= NUM_SETS)
        begin
            res.status = ST_BADSET;
            return res;
        end

        s = o.set_index;
        n = occ_mirror[s];
        res.set_occupancy = OCC_OUT_W'(n);

        if (o.kind == KIND_READ)
        begin
            if (o.position >= n)
            begin
                res.status = ST_BADPOS;
            end
            else
            begin
                res.status      = ST_READ;
                res.entry_key   = key_mirror[s][o.position];
                res.entry_count = count_mirror[s][o.position];
            end
            return res;
        end

        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[s][mid] < o.key)
                lo = mid + 1;
            else
                hi = mid;
        end

        if (lo < n && key_mirror[s][lo] == o.key)
        begin
            // wraps modulo 2^32
            count_mirror[s][lo] = count_mirror[s][lo] + o.increment;
            res.status = ST_INCR;
        end
        else if (n >= SET_CAPACITY)
        begin
            res.status = ST_FULL;
        end
        else
        begin
            for (j = n; j > lo; j--)
            begin
                key_mirror[s][j]   = key_mirror[s][j-1];
                count_mirror[s][j] = count_mirror[s][j-1];
            end
            key_mirror[s][lo]   = o.key;
            count_mirror[s][lo] = o.increment;
            occ_mirror[s]       = n + 1;
            res.status          = ST_NEW;
            res.set_occupancy   = OCC_OUT_W'(n + 1);
        end
        return res;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind, input int set_index,
                                    input logic [KEY_W-1:0] key,
                                    input logic signed [CNT_W-1:0] increment,
                                    input int position, input bit typed,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [KEY_W-1:0] entry_key,
                                    input logic signed [CNT_W-1:0] entry_count,
                                    input int occupancy);
        plan_row_t row;
        row.op.kind                = kind;
        row.op.set_index           = SET_W'(set_index);
        row.op.key                 = key;
        row.op.increment           = increment;
        row.op.position            = POS_W'(position);
        row.typed                  = typed;
        row.want.status            = status;
        row.want.entry_key         = entry_key;
        row.want.entry_count       = entry_count;
        row.want.set_occupancy     = OCC_OUT_W'(occupancy);
        plan.push_back(row);
    endfunction

    // Random request. Sets come from a small pool so keys repeat and lists
    // grow; a few requests go to bad sets and a few clear everything.
    function automatic op_t rand_op();
        op_t o;
        int  pool [6];
        int  pick;
        int  r;
        int  s;
        int  n;

        pool = '{0, 1, 2, 3, 7, 31};

        o.kind      = KIND_INSERT;
        o.set_index = SET_W'($urandom);
        o.key       = {$urandom, $urandom};
        o.increment = $urandom;
        o.position  = POS_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            o.kind = pick[0] ? KIND_CLEAR_HI : KIND_CLEAR;
            return o;
        end
        if (pick < 9)
        begin
            o.set_index = SET_W'($urandom_range(NUM_SETS, 255));
            if ($urandom_range(0, 1) != 0)
                o.kind = KIND_READ;
            return o;
        end

        s = pool[$urandom_range(0, 5)];
        o.set_index = SET_W'(s);
        n = occ_mirror[s];

        if ($urandom_range(0, 99) < 35)
        begin
            o.kind = KIND_READ;
            if (n > 0 && $urandom_range(0, 4) != 0)
                o.position = POS_W'($urandom_range(0, n - 1));
            return o;
        end

        r = $urandom_range(0, 19);
        if (r == 0)
            o.increment = CNT_MAX;
        else if (r == 1)
            o.increment = CNT_MIN;
        else if (r == 2)
            o.increment = -1;
        else if (r == 3)
            o.increment = 0;

        r = $urandom_range(0, 9);
        if (n > 0 && r < 4)
        begin
            o.key = key_mirror[s][$urandom_range(0, n - 1)];
        end
        else if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0:       o.key = '0;
                1:       o.key = KEY_ONES;
                2:       o.key = 64'd1;
                default: o.key = 64'h8000_0000_0000_0000;
            endcase
        end
        return o;
    endfunction

    // One request transfer. valid stays high across back-to-back transfers so
    // it never takes two assignments in one step. Prediction runs at acceptance.
    task automatic issue(input op_t o, input bit typed, input outcome_t want);
        outcome_t predicted;
        int       gap;

        if ($urandom_range(0, 49) == 0)
            quiet = !quiet;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= o.kind;
        req_ch.set_index <= o.set_index;
        req_ch.key       <= o.key;
        req_ch.increment <= o.increment;
        req_ch.position  <= o.position;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = count_table_step(o);
        due_outcomes.push_back(typed ? want : predicted);
        sent++;
    endtask

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        errors++;
        if (reported < REPORT_MAX)
        begin
            reported++;
            $display("%0t MISMATCH %s: expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endfunction

    // Request side: directed table, then random traffic
    initial
    begin : req_side
        op_t      o;
        outcome_t none;
        int       i;

        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_INSERT;
        req_ch.set_index = '0;
        req_ch.key       = '0;
        req_ch.increment = '0;
        req_ch.position  = '0;
        for (i = 0; i < NUM_SETS; i++)
            occ_mirror[i] = 0;
        errors    = 0;
        reported  = 0;
        sent      = 0;
        cycles    = 0;
        quiet     = 1'b0;
        stim_done = 1'b0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        none.status        = ST_NEW;
        none.entry_key     = '0;
        none.entry_count   = '0;
        none.set_occupancy = '0;

        // After reset: nothing to read anywhere
        add_row(KIND_READ,     0,        '0, 0,  0,    1, ST_BADPOS, '0, 0, 0);
        // Set index out of range, top value and first bad value
        add_row(KIND_INSERT,   255, KEY_ONES, 1, 1023, 1, ST_BADSET, '0, 0, 0);
        add_row(KIND_READ,     NUM_SETS, '0, 0,  0,    1, ST_BADSET, '0, 0, 0);
        // Key extremes with count extremes
        add_row(KIND_INSERT,   0,  KEY_ONES, CNT_MAX, 0, 1, ST_NEW,  '0, 0, 1);
        add_row(KIND_INSERT,   0,        '0, CNT_MIN, 0, 1, ST_NEW,  '0, 0, 2);
        // Increment past the top: count wraps to the most negative value
        add_row(KIND_INSERT,   0,  KEY_ONES, 1,       0, 1, ST_INCR, '0, 0, 2);
        add_row(KIND_READ,     0,        '0, 0,       0, 1, ST_READ, '0, CNT_MIN, 2);
        add_row(KIND_READ,     0,        '0, 0,       1, 1, ST_READ, KEY_ONES, CNT_MIN, 2);
        add_row(KIND_READ,     0,        '0, 0,    1023, 1, ST_BADPOS, '0, 0, 2);
        // Insert in the middle shifts the top entry up
        add_row(KIND_INSERT,   0, 64'h8000_0000_0000_0000, 5, 0, 0, ST_NEW, '0, 0, 0);
        add_row(KIND_READ,     0,        '0, 0,       1, 0, ST_NEW,  '0, 0, 0);
        add_row(KIND_READ,     0,        '0, 0,       2, 0, ST_NEW,  '0, 0, 0);
        // Decrement below the bottom wraps to the top
        add_row(KIND_INSERT,   0,        '0, -1,      0, 1, ST_INCR, '0, 0, 3);
        add_row(KIND_READ,     0,        '0, 0,       0, 1, ST_READ, '0, CNT_MAX, 3);
        add_row(KIND_INSERT,   31,   64'd1, 0,        0, 1, ST_NEW,  '0, 0, 1);
        add_row(KIND_READ,     31,       '0, 0,       1, 1, ST_BADPOS, '0, 0, 1);
        // Clear ignores every other field and empties all sets
        add_row(KIND_CLEAR,    31, KEY_ONES, -1,   1023, 1, ST_CLEAR, '0, 0, 0);
        add_row(KIND_READ,     0,        '0, 0,       0, 1, ST_BADPOS, '0, 0, 0);
        // Reuse of a cleared set over stale storage
        add_row(KIND_INSERT,   0,    64'd5, 3,        0, 0, ST_NEW,  '0, 0, 0);
        add_row(KIND_READ,     0,        '0, 0,       0, 0, ST_NEW,  '0, 0, 0);
        // Kind three also clears
        add_row(KIND_CLEAR_HI, 200,      '0, 0,       0, 1, ST_CLEAR, '0, 0, 0);
        add_row(KIND_READ,     0,        '0, 0,       0, 1, ST_BADPOS, '0, 0, 0);
        add_row(KIND_INSERT,   7, 64'h0123_4567_89AB_CDEF, 9,  0, 0, ST_NEW, '0, 0, 0);
        add_row(KIND_INSERT,   7, 64'h0123_4567_89AB_CDEE, -9, 0, 0, ST_NEW, '0, 0, 0);
        add_row(KIND_READ,     7,        '0, 0,       1, 0, ST_NEW,  '0, 0, 0);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (plan[r])
            issue(plan[r].op, plan[r].typed, plan[r].want);

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            o = rand_op();
            issue(o, 1'b0, none);
        end

        req_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stalls on ready, in-order compare against the queue
    initial
    begin : rsp_side
        outcome_t want;
        int       stall;

        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);

            // transfer at this edge
            status_seen[rsp_ch.status]++;
            if (due_outcomes.size() == 0)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("%0t MISMATCH unexpected result: status %0d occupancy %0d",
                             $time, rsp_ch.status, rsp_ch.set_occupancy);
                end
            end
            else
            begin
                want = due_outcomes.pop_front();
                if (rsp_ch.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
                if (rsp_ch.entry_key !== want.entry_key)
                    note_mismatch("entry_key", want.entry_key, rsp_ch.entry_key);
                if (rsp_ch.entry_count !== want.entry_count)
                    note_mismatch("entry_count", 64'(unsigned'(want.entry_count)),
                                  64'(unsigned'(rsp_ch.entry_count)));
                if (rsp_ch.set_occupancy !== want.set_occupancy)
                    note_mismatch("set_occupancy", 64'(want.set_occupancy),
                                  64'(rsp_ch.set_occupancy));
            end
        end
    end

    // End of run: drain, let a few more cycles pass for stray results, report
    initial
    begin : finish_side
        wait (stim_done === 1'b1);
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d requests over %0d cycles: directed table, then random traffic",
                 sent, cycles);
        $display("results: new %0d incr %0d read %0d clear %0d badset %0d full %0d badpos %0d",
                 status_seen[ST_NEW], status_seen[ST_INCR], status_seen[ST_READ],
                 status_seen[ST_CLEAR], status_seen[ST_BADSET], status_seen[ST_FULL],
                 status_seen[ST_BADPOS]);
        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("tb: errors");
        end
        $finish;
    end

endmodule
